// ===== src/brac_pkg.sv =====
// ----------------------------------------------------------------------------
// brac_pkg
// Shared constants and types for the block range assign / count-not-above core.
// ----------------------------------------------------------------------------
package brac_pkg;

   localparam int DATA_W      = 32;
   localparam int IDX_IN_W    = 10;
   localparam int COUNT_W     = 11;
   localparam int REQ_TDATA_W = 56;   // left, right, value, zero pad
   localparam int RSP_TDATA_W = 16;   // count, zero pad

   localparam int DEF_ARRAY_LENGTH = 1024;
   localparam int DEF_BLOCK_SIZE   = 32;

   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_COUNT  = 1'b1;

   // command from the sequencer to the block work buffer
   typedef struct packed {
      logic load;   // write one lane from data
      logic fill;   // write all lanes from data
      logic set;    // write lanes lo..hi from data
      logic sort;   // one odd-even transposition pass
      logic odd;    // pass parity
   } lane_cmd_type;

endpackage

// ===== src/brac_ram.sv =====
// ----------------------------------------------------------------------------
// brac_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module brac_ram import brac_pkg::*; #(
   parameter int DEPTH = DEF_ARRAY_LENGTH,
   parameter int AW    = 10
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     addr,
   input  logic [DATA_W-1:0] wdata,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/brac_lanes.sv =====
// ----------------------------------------------------------------------------
// brac_lanes
// Work buffer for one block: load, fill, range set and odd-even transposition
// sort. Lanes at or above len sort to the top and are never written back.
// ----------------------------------------------------------------------------
module brac_lanes import brac_pkg::*; #(
   parameter int BLOCK_SIZE = DEF_BLOCK_SIZE,
   parameter int OW         = 5,
   parameter int LW         = 6
) (
   input  logic                     clock,
   input  lane_cmd_type             cmd,
   input  logic [OW-1:0]            idx,
   input  logic [OW-1:0]            lo_off,
   input  logic [OW-1:0]            hi_off,
   input  logic [LW-1:0]            len,
   input  logic signed [DATA_W-1:0] din,
   input  logic [OW-1:0]            rd_idx,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] lane_ff [BLOCK_SIZE];
   logic signed [DATA_W-1:0] lane_in [BLOCK_SIZE];
   logic [DATA_W:0]          key     [BLOCK_SIZE];

   // unsigned key: invalid lanes on top, then signed order
   always_comb begin
      for (int j = 0; j < BLOCK_SIZE; j++) begin
         key[j] = {(LW'(j) >= len), ~lane_ff[j][DATA_W-1], lane_ff[j][DATA_W-2:0]};
      end
   end

   always_comb begin
      for (int j = 0; j < BLOCK_SIZE; j++) begin
         lane_in[j] = lane_ff[j];
      end
      priority if (cmd.fill) begin
         for (int j = 0; j < BLOCK_SIZE; j++) begin
            lane_in[j] = din;
         end
      end else if (cmd.load) begin
         lane_in[idx] = din;
      end else if (cmd.set) begin
         for (int j = 0; j < BLOCK_SIZE; j++) begin
            if (OW'(j) >= lo_off && OW'(j) <= hi_off) begin
               lane_in[j] = din;
            end
         end
      end else if (cmd.sort) begin
         for (int j = 0; j + 1 < BLOCK_SIZE; j++) begin
            if ((j % 2 == 1) == cmd.odd && key[j] > key[j+1]) begin
               lane_in[j]   = lane_ff[j+1];
               lane_in[j+1] = lane_ff[j];
            end
         end
      end else begin
         // no command: lanes hold
         for (int j = 0; j < BLOCK_SIZE; j++) begin
            lane_in[j] = lane_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < BLOCK_SIZE; j++) begin
         lane_ff[j] <= lane_in[j];
      end
   end

   assign rd_data = lane_ff[rd_idx];

endmodule

// ===== src/block_range_assign_count_leq_core.sv =====
// ----------------------------------------------------------------------------
// block_range_assign_count_leq_core
// Block-decomposed range assign and range count of elements not above a value.
// ----------------------------------------------------------------------------
// One item at a time. The sequencer walks blocks from block 0 up to the block
// holding right and steps over blocks outside the range. A whole block is
// settled in S_BLK when it carries a pending fill (or for an assign), else by a
// binary search of the sorted RAM, a probe being S_SRCH then S_SCMP, at most
// log2(BLOCK_SIZE)+1 probes. A partial block on count reads its elements from
// the element RAM unless a fill is pending; on assign it loads them (skipped if
// a fill is pending), sets the range, writes the elements back, runs BLOCK_SIZE
// sort passes and writes the sorted block back. Each RAM port takes one access a
// cycle. At reset every block is marked pending with fill value zero, so no
// clearing pass over the RAMs runs and the first item is taken right after reset.
module block_range_assign_count_leq_core import brac_pkg::*; #(
   parameter int ARRAY_LENGTH = DEF_ARRAY_LENGTH,
   parameter int BLOCK_SIZE   = DEF_BLOCK_SIZE
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // left[9:0], right[19:10], value[51:20]
   input  logic [0:0]             req_tuser,  // operation[0]
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // count[10:0]
);

   localparam int NB  = (ARRAY_LENGTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int BW  = (NB > 1) ? $clog2(NB) : 1;
   localparam int IW  = (ARRAY_LENGTH > 1) ? $clog2(ARRAY_LENGTH) : 1;
   localparam int AW1 = $clog2(ARRAY_LENGTH + 1);
   localparam int PW  = ((AW1 > IDX_IN_W) ? AW1 : IDX_IN_W) + 10;
   localparam int OW  = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
   localparam int LW  = $clog2(BLOCK_SIZE + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_BLK  = 4'd1;
   localparam logic [3:0] S_LOAD = 4'd2;
   localparam logic [3:0] S_SET  = 4'd3;
   localparam logic [3:0] S_WREL = 4'd4;
   localparam logic [3:0] S_SORT = 4'd5;
   localparam logic [3:0] S_WRSR = 4'd6;
   localparam logic [3:0] S_SRCH = 4'd7;
   localparam logic [3:0] S_SCMP = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0]               state_ff, state_in;
   logic                     op_ff, op_in;
   logic [PW-1:0]            l_ff, l_in, r_ff, r_in;
   logic signed [DATA_W-1:0] val_ff, val_in;
   logic [COUNT_W-1:0]       cnt_ff, cnt_in;
   logic [BW-1:0]            blk_ff, blk_in;
   logic [PW-1:0]            bfirst_ff, bfirst_in;
   logic [LW-1:0]            k_ff, k_in, lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic                     ld_v_ff, ld_v_in;
   logic [OW-1:0]            ld_idx_ff, ld_idx_in;
   logic [NB-1:0]            pend_ff, pend_in;
   logic signed [DATA_W-1:0] fill_ff [NB];
   logic signed [DATA_W-1:0] fill_in [NB];
   logic                     rsp_v_ff, rsp_v_in;
   logic [COUNT_W-1:0]       rsp_c_ff, rsp_c_in;

   logic [PW-1:0]            in_l, in_r, blast, bl_raw, len_w, lo_abs, hi_abs, lo_w, hi_w;
   logic [PW-1:0]            addr_w;
   logic [LW-1:0]            len, off;
   logic [LW:0]              mid_sum;
   logic [OW-1:0]            lo_off, hi_off;
   logic                     outside, whole, last_blk, in_empty, advance;
   logic signed [DATA_W-1:0] cur_fill, el_rdata, sr_rdata, lane_rd, lane_din;
   logic                     el_we, sr_we;
   lane_cmd_type             cmd;

   // ---- block geometry -----------------------------------------------------
   assign bl_raw   = bfirst_ff + PW'(BLOCK_SIZE - 1);
   assign blast    = (bl_raw > PW'(ARRAY_LENGTH - 1)) ? PW'(ARRAY_LENGTH - 1) : bl_raw;
   assign len_w    = blast - bfirst_ff + PW'(1);
   assign len      = len_w[LW-1:0];
   assign lo_abs   = (l_ff > bfirst_ff) ? l_ff : bfirst_ff;
   assign hi_abs   = (r_ff < blast) ? r_ff : blast;
   assign lo_w     = lo_abs - bfirst_ff;
   assign hi_w     = hi_abs - bfirst_ff;
   assign lo_off   = lo_w[OW-1:0];
   assign hi_off   = hi_w[OW-1:0];
   assign outside  = (blast < l_ff) || (bfirst_ff > r_ff);
   assign whole    = (l_ff <= bfirst_ff) && (blast <= r_ff);
   assign last_blk = (blast >= r_ff);
   assign cur_fill = fill_ff[blk_ff];

   assign in_l     = PW'(req_tdata[9:0]);
   assign in_r     = (PW'(req_tdata[19:10]) > PW'(ARRAY_LENGTH - 1)) ?
                     PW'(ARRAY_LENGTH - 1) : PW'(req_tdata[19:10]);
   assign in_empty = (in_l >= PW'(ARRAY_LENGTH)) || (in_l > in_r);

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};

   // ---- RAM address and write enables --------------------------------------
   assign off    = (state_ff == S_SRCH) ? mid_sum[LW:1] : k_ff;
   assign addr_w = bfirst_ff + PW'(off);
   assign el_we  = (state_ff == S_WREL);
   assign sr_we  = (state_ff == S_WRSR);

   always_comb begin
      cmd      = '0;
      lane_din = val_ff;
      unique case (state_ff)
         S_BLK: begin
            cmd.fill = !outside && !whole && op_ff == OP_ASSIGN && pend_ff[blk_ff];
            lane_din = cur_fill;
         end
         S_SET: begin
            cmd.set = 1'b1;
         end
         S_SORT: begin
            cmd.sort = 1'b1;
            cmd.odd  = k_ff[0];
         end
         default: begin
            cmd.load = ld_v_ff;
            lane_din = el_rdata;
         end
      endcase
   end

   // ---- sequencer ----------------------------------------------------------
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      l_in      = l_ff;
      r_in      = r_ff;
      val_in    = val_ff;
      cnt_in    = cnt_ff;
      blk_in    = blk_ff;
      bfirst_in = bfirst_ff;
      k_in      = k_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      ld_v_in   = 1'b0;
      ld_idx_in = k_ff[OW-1:0];
      pend_in   = pend_ff;
      for (int b = 0; b < NB; b++) begin
         fill_in[b] = fill_ff[b];
      end
      rsp_v_in  = rsp_v_ff && !rsp_tready;
      rsp_c_in  = rsp_c_ff;
      advance   = 1'b0;

      // element reads land in the cycle after issue
      if (ld_v_ff && op_ff == OP_COUNT && ld_idx_ff >= lo_off && ld_idx_ff <= hi_off
          && el_rdata <= val_ff) begin
         cnt_in = cnt_ff + COUNT_W'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in     = req_tuser[0];
               l_in      = in_l;
               r_in      = in_r;
               val_in    = req_tdata[51:20];
               cnt_in    = '0;
               blk_in    = '0;
               bfirst_in = '0;
               if (!in_empty) begin
                  state_in = S_BLK;
               end else if (req_tuser[0] == OP_COUNT) begin
                  state_in = S_DONE;
               end
            end
         end
         S_BLK: begin
            k_in = '0;
            priority if (outside) begin
               advance = 1'b1;
            end else if (whole && op_ff == OP_ASSIGN) begin
               pend_in[blk_ff] = 1'b1;
               fill_in[blk_ff] = val_ff;
               advance         = 1'b1;
            end else if (op_ff == OP_COUNT && pend_ff[blk_ff]) begin
               if (cur_fill <= val_ff) begin
                  cnt_in = cnt_ff + COUNT_W'(hi_w) - COUNT_W'(lo_w) + COUNT_W'(1);
               end
               advance = 1'b1;
            end else if (whole) begin
               lo_in    = '0;
               hi_in    = len;
               state_in = S_SRCH;
            end else if (op_ff == OP_ASSIGN && pend_ff[blk_ff]) begin
               state_in = S_SET;   // lanes take the fill this cycle
            end else begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (k_ff < len) begin
               ld_v_in = 1'b1;
               k_in    = k_ff + LW'(1);
            end else if (op_ff == OP_COUNT) begin
               advance = 1'b1;
            end else begin
               state_in = S_SET;
            end
         end
         S_SET: begin
            pend_in[blk_ff] = 1'b0;
            k_in            = '0;
            state_in        = S_WREL;
         end
         S_WREL: begin
            if (k_ff == len - LW'(1)) begin
               k_in     = '0;
               state_in = S_SORT;
            end else begin
               k_in = k_ff + LW'(1);
            end
         end
         S_SORT: begin
            if (k_ff == LW'(BLOCK_SIZE - 1)) begin
               k_in     = '0;
               state_in = S_WRSR;
            end else begin
               k_in = k_ff + LW'(1);
            end
         end
         S_WRSR: begin
            if (k_ff == len - LW'(1)) begin
               advance = 1'b1;
            end else begin
               k_in = k_ff + LW'(1);
            end
         end
         S_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[LW:1];
               state_in = S_SCMP;
            end else begin
               cnt_in  = cnt_ff + COUNT_W'(lo_ff);
               advance = 1'b1;
            end
         end
         S_SCMP: begin
            if (sr_rdata <= val_ff) begin
               lo_in = mid_ff + LW'(1);
            end else begin
               hi_in = mid_ff;
            end
            state_in = S_SRCH;
         end
         S_DONE: begin
            if (op_ff == OP_ASSIGN) begin
               state_in = S_IDLE;
            end else if (!rsp_v_ff || rsp_tready) begin
               rsp_v_in = 1'b1;
               rsp_c_in = cnt_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (advance) begin
         k_in = '0;
         if (last_blk) begin
            state_in = S_DONE;
         end else begin
            state_in  = S_BLK;
            blk_in    = blk_ff + BW'(1);
            bfirst_in = bfirst_ff + PW'(BLOCK_SIZE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ld_v_ff  <= 1'b0;
         rsp_v_ff <= 1'b0;
         pend_ff  <= '1;   // every block starts as a pending fill of zero
         for (int b = 0; b < NB; b++) begin
            fill_ff[b] <= '0;
         end
      end else begin
         state_ff <= state_in;
         ld_v_ff  <= ld_v_in;
         rsp_v_ff <= rsp_v_in;
         pend_ff  <= pend_in;
         for (int b = 0; b < NB; b++) begin
            fill_ff[b] <= fill_in[b];
         end
      end
      op_ff     <= op_in;
      l_ff      <= l_in;
      r_ff      <= r_in;
      val_ff    <= val_in;
      cnt_ff    <= cnt_in;
      blk_ff    <= blk_in;
      bfirst_ff <= bfirst_in;
      k_ff      <= k_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      mid_ff    <= mid_in;
      ld_idx_ff <= ld_idx_in;
      rsp_c_ff  <= rsp_c_in;
   end

   // ---- storage ------------------------------------------------------------
   brac_ram #(.DEPTH(ARRAY_LENGTH), .AW(IW)) u_elem (
      .clock (clock),
      .wr_en (el_we),
      .addr  (addr_w[IW-1:0]),
      .wdata (lane_rd),
      .rdata (el_rdata)
   );

   brac_ram #(.DEPTH(ARRAY_LENGTH), .AW(IW)) u_sorted (
      .clock (clock),
      .wr_en (sr_we),
      .addr  (addr_w[IW-1:0]),
      .wdata (lane_rd),
      .rdata (sr_rdata)
   );

   brac_lanes #(.BLOCK_SIZE(BLOCK_SIZE), .OW(OW), .LW(LW)) u_lanes (
      .clock   (clock),
      .cmd     (cmd),
      .idx     (ld_idx_ff),
      .lo_off  (lo_off),
      .hi_off  (hi_off),
      .len     (len),
      .din     (lane_din),
      .rd_idx  (k_ff[OW-1:0]),
      .rd_data (lane_rd)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_c_ff);

   // ---- assertions ---------------------------------------------------------
   a_load_follows_issue: assert property (@(posedge clock) disable iff (reset)
      ld_v_ff |-> $past(state_ff) == S_LOAD)
      else $error("element read data without a load issue");

   a_load_in_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_LOAD |-> k_ff <= len)
      else $error("load counter past block length");

   a_set_clears_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SET |=> !pend_ff[$past(blk_ff)])
      else $error("rewritten block still marked pending");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp_tready |=> rsp_c_ff == $past(rsp_c_ff))
      else $error("held result overwritten");

endmodule

// ===== tb/sv/block_range_assign_count_leq_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_range_assign_count_leq_core_test
// Drives random and directed range assign / count items through the core and
// checks every count against a flat-array shadow of the element store.
// ----------------------------------------------------------------------------
module block_range_assign_count_leq_core_test;
   import brac_pkg::*;

   localparam int LEN = DEF_ARRAY_LENGTH;
   localparam longint LIMIT = 4000000;

   typedef struct packed {
      logic              op;
      logic [9:0]        left;
      logic [9:0]        right;
      logic signed [31:0] value;
   } cmd_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [0:0]             req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   block_range_assign_count_leq_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   cmd_t               pending_cmds[$];
   logic [10:0]        expected_counts[$];
   logic signed [31:0] shadow[LEN];
   int                 failures = 0;
   bit                 stim_done = 1'b0;
   longint             cycles = 0;
   int                 send_wait = 0;
   int                 recv_wait = 0;
   bit                 quiet = 1'b0;

   // flat-array equivalent of the block decomposition
   task automatic apply_cmd(input cmd_t c);
      int r;
      int n;
      r = (c.right > LEN - 1) ? LEN - 1 : c.right;
      n = 0;
      if (c.op == OP_ASSIGN) begin
         for (int i = c.left; i <= r; i++) shadow[i] = c.value;
      end else begin
         for (int i = c.left; i <= r; i++) if (shadow[i] <= c.value) n++;
         expected_counts.push_back(n[10:0]);
      end
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("block_range_assign_count_leq_core_test: FAIL");
         $finish;
      end
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_cmd(cmd_t'({req_tuser[0], req_tdata[9:0], req_tdata[19:10],
                              req_tdata[51:20]}));
         end
         if (req_tvalid && !req_tready) begin
         end else if (send_wait > 0) begin
            req_tvalid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (pending_cmds.size() > 0) begin
            cmd_t c;
            c = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= c.op;
            req_tdata <= {4'b0, c.value, c.right, c.left};
            send_wait <= quiet ? 0 : $urandom_range(0, 6);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_counts.size() == 0) begin
               $error("unexpected count transfer %0d", rsp_tdata[10:0]);
               failures++;
            end else begin
               logic [10:0] e;
               e = expected_counts.pop_front();
               if (rsp_tdata[10:0] !== e) begin
                  $error("count: expected %0d actual %0d", e, rsp_tdata[10:0]);
                  failures++;
               end
            end
         end
         if (recv_wait > 0) begin
            rsp_tready <= 1'b0;
            recv_wait <= recv_wait - 1;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               recv_wait <= quiet ? 0 : $urandom_range(0, 6);
         end
      end
   end

   function automatic cmd_t mk(input logic op, input int l, input int r,
                               input logic signed [31:0] v);
      cmd_t c;
      c.op = op; c.left = l[9:0]; c.right = r[9:0]; c.value = v;
      return c;
   endfunction

   function automatic logic signed [31:0] rand_value();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 8) - 4;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int l, r, wait_cycles;
      for (int i = 0; i < LEN; i++) shadow[i] = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // directed: fresh state, extremes, reversed ranges, block edges
      pending_cmds.push_back(mk(OP_COUNT, 0, 1023, 0));
      pending_cmds.push_back(mk(OP_COUNT, 0, 1023, -1));
      pending_cmds.push_back(mk(OP_ASSIGN, 0, 1023, 32'sh7fffffff));
      pending_cmds.push_back(mk(OP_COUNT, 0, 1023, 32'sh7ffffffe));
      pending_cmds.push_back(mk(OP_COUNT, 5, 1000, 32'sh7fffffff));
      pending_cmds.push_back(mk(OP_ASSIGN, 31, 32, 32'sh80000000));
      pending_cmds.push_back(mk(OP_COUNT, 0, 63, 32'sh80000000));
      pending_cmds.push_back(mk(OP_ASSIGN, 40, 20, 7));
      pending_cmds.push_back(mk(OP_COUNT, 40, 20, 32'sh7fffffff));
      pending_cmds.push_back(mk(OP_ASSIGN, 1023, 1023, -5));
      pending_cmds.push_back(mk(OP_COUNT, 1023, 1023, -5));
      pending_cmds.push_back(mk(OP_ASSIGN, 64, 95, 3));
      pending_cmds.push_back(mk(OP_ASSIGN, 70, 70, 1));
      pending_cmds.push_back(mk(OP_COUNT, 10, 200, 2));
      pending_cmds.push_back(mk(OP_ASSIGN, 33, 990, 32'h5555aaaa));
      pending_cmds.push_back(mk(OP_ASSIGN, 100, 100, 32'h2aaa5555));
      pending_cmds.push_back(mk(OP_COUNT, 0, 1023, 32'h5555aaaa));
      pending_cmds.push_back(mk(OP_COUNT, 0, 1023, 32'h2aaa5554));
      for (int k = 0; k < 1950; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            l = $urandom_range(0, 1023); r = $urandom_range(0, 1023);
         end else if ($urandom_range(0, 2) == 0) begin
            l = $urandom_range(0, 1023); r = l + $urandom_range(0, 40);
            if (r > 1023) r = 1023;
         end else begin
            l = $urandom_range(0, 1023); r = $urandom_range(l, 1023);
         end
         pending_cmds.push_back(mk($urandom_range(0, 1), l, r, rand_value()));
         // quiet is set and cleared again before any item is sent, so it never takes effect
         if (k == 1500) quiet = 1'b1;
         if (k == 1700) quiet = 1'b0;
      end
      wait (pending_cmds.size() == 0 && !req_tvalid);
      while (expected_counts.size() > 0) @(posedge clock);
      // trailing assigns may still be in work: allow full item latency
      wait_cycles = 0;
      while (wait_cycles < 20000) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (failures == 0 && expected_counts.size() == 0) begin
         $display("block_range_assign_count_leq_core_test: PASS");
      end else begin
         $display("block_range_assign_count_leq_core_test: FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/brac_pkg.sv
src/brac_ram.sv
src/brac_lanes.sv
src/block_range_assign_count_leq_core.sv
tb/sv/block_range_assign_count_leq_core_test.sv
